// ===== rtl/cfi_pkg.sv =====
// Shared types, command codes and the query table of the flash command engine.
`timescale 1ns / 1ps
`default_nettype none

package cfi_pkg;

    localparam int unsigned BUS_BYTES     = 1;
    localparam int unsigned QUERY_ENTRIES = 64;
    localparam int unsigned QUERY_AW      = $clog2(QUERY_ENTRIES);

    localparam logic [7:0] CMD_READ_ARRAY    = 8'h00;
    localparam logic [7:0] CMD_PROGRAM       = 8'h10;
    localparam logic [7:0] CMD_PROGRAM_ALT   = 8'h40;
    localparam logic [7:0] CMD_ERASE         = 8'h20;
    localparam logic [7:0] CMD_ERASE_ALT     = 8'h28;
    localparam logic [7:0] CMD_LOCK          = 8'h60;
    localparam logic [7:0] CMD_QUERY         = 8'h98;
    localparam logic [7:0] CMD_BUFFER_WRITE  = 8'he8;
    localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
    localparam logic [7:0] CMD_READ_ID       = 8'h90;
    localparam logic [7:0] CMD_CLEAR_STATUS  = 8'h50;
    localparam logic [7:0] CMD_CONFIRM       = 8'hd0;
    localparam logic [7:0] CMD_LOCK_CONFIRM  = 8'h01;
    localparam logic [7:0] CMD_RESET         = 8'hff;

    localparam logic [7:0] STAT_READY        = 8'h80;
    localparam logic [7:0] STAT_PROGRAM_ERR  = 8'h10;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic       store_en;
        logic       array_rd;
        logic [7:0] rd_byte;
    } cmd_resp_t;

    function automatic logic [7:0] query_byte(input logic [QUERY_AW-1:0] idx);
        logic [7:0] val;
        case (idx)
            6'h10:   val = 8'h51;
            6'h11:   val = 8'h52;
            6'h12:   val = 8'h59;
            6'h13:   val = 8'h01;
            6'h15:   val = 8'h31;
            6'h1b:   val = 8'h45;
            6'h1c:   val = 8'h55;
            6'h1f:   val = 8'h07;
            6'h20:   val = 8'h07;
            6'h21:   val = 8'h0a;
            6'h23:   val = 8'h04;
            6'h24:   val = 8'h04;
            6'h25:   val = 8'h04;
            6'h27:   val = 8'h22;
            6'h28:   val = 8'h02;
            6'h2a:   val = 8'h08;
            6'h2c:   val = 8'h01;
            6'h2d:   val = 8'hff;
            6'h2e:   val = 8'h03;
            6'h2f:   val = 8'h10;
            6'h31:   val = 8'h50;
            6'h32:   val = 8'h52;
            6'h33:   val = 8'h49;
            6'h34:   val = 8'h31;
            6'h35:   val = 8'h30;
            6'h3f:   val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfi_req_if.sv =====
// Bus access channel: valid/ready handshake with opcode, address and write data.
`timescale 1ns / 1ps
`default_nettype none

interface cfi_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/cfi_rsp_if.sv =====
// Read data channel: valid/ready handshake with the returned byte.
`timescale 1ns / 1ps
`default_nettype none

interface cfi_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfi_cmd_decoder.sv =====
// Command state machine: command code, write cycle, status and buffer countdown.
`timescale 1ns / 1ps
`default_nettype none

module cfi_cmd_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         opcode,
    input  wire logic                         in_range,
    input  wire logic [cfi_pkg::QUERY_AW-1:0] query_idx,
    input  wire logic [7:0]                   write_data,
    output cfi_pkg::cmd_resp_t                resp
);

    typedef enum logic [1:0] {
        WC_FIRST,
        WC_SECOND,
        WC_DATA,
        WC_CONFIRM
    } wcycle_t;

    logic [7:0] cmd_reg, cmd_next;
    wcycle_t    wc_reg, wc_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] count_reg, count_next;

    always_comb
    begin
        cmd_next      = cmd_reg;
        wc_next       = wc_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        resp.store_en = 1'b0;
        resp.array_rd = 1'b0;
        resp.rd_byte  = 8'h00;

        if (opcode == cfi_pkg::OP_WRITE)
        begin
            unique case (wc_reg)
                WC_FIRST:
                begin
                    unique case (write_data) inside
                        cfi_pkg::CMD_PROGRAM, cfi_pkg::CMD_PROGRAM_ALT,
                        cfi_pkg::CMD_ERASE, cfi_pkg::CMD_ERASE_ALT,
                        cfi_pkg::CMD_LOCK, cfi_pkg::CMD_QUERY:
                        begin
                            cmd_next = write_data;
                            wc_next  = WC_SECOND;
                        end
                        cfi_pkg::CMD_BUFFER_WRITE:
                        begin
                            status_next = status_reg | cfi_pkg::STAT_READY;
                            cmd_next    = write_data;
                            wc_next     = WC_SECOND;
                        end
                        cfi_pkg::CMD_READ_STATUS, cfi_pkg::CMD_READ_ID:
                        begin
                            cmd_next = write_data;
                        end
                        cfi_pkg::CMD_CLEAR_STATUS:
                        begin
                            status_next = 8'h00;
                            cmd_next    = cfi_pkg::CMD_READ_ARRAY;
                            wc_next     = WC_FIRST;
                        end
                        default:
                        begin
                            cmd_next = cfi_pkg::CMD_READ_ARRAY;
                            wc_next  = WC_FIRST;
                        end
                    endcase
                end
                WC_SECOND:
                begin
                    unique case (cmd_reg) inside
                        cfi_pkg::CMD_PROGRAM, cfi_pkg::CMD_PROGRAM_ALT:
                        begin
                            resp.store_en = in_range;
                            status_next   = status_reg | cfi_pkg::STAT_READY;
                            wc_next       = WC_FIRST;
                        end
                        cfi_pkg::CMD_ERASE, cfi_pkg::CMD_ERASE_ALT:
                        begin
                            if (write_data == cfi_pkg::CMD_CONFIRM)
                            begin
                                wc_next     = WC_FIRST;
                                status_next = status_reg | cfi_pkg::STAT_READY;
                            end
                            else
                            begin
                                cmd_next = cfi_pkg::CMD_READ_ARRAY;
                                wc_next  = WC_FIRST;
                            end
                        end
                        cfi_pkg::CMD_LOCK:
                        begin
                            if (write_data == cfi_pkg::CMD_CONFIRM ||
                                write_data == cfi_pkg::CMD_LOCK_CONFIRM)
                            begin
                                wc_next     = WC_FIRST;
                                status_next = status_reg | cfi_pkg::STAT_READY;
                            end
                            else
                            begin
                                cmd_next = cfi_pkg::CMD_READ_ARRAY;
                                wc_next  = WC_FIRST;
                            end
                        end
                        cfi_pkg::CMD_BUFFER_WRITE:
                        begin
                            count_next = write_data;
                            wc_next    = WC_DATA;
                        end
                        cfi_pkg::CMD_QUERY:
                        begin
                            if (write_data == cfi_pkg::CMD_RESET)
                            begin
                                cmd_next = cfi_pkg::CMD_READ_ARRAY;
                                wc_next  = WC_FIRST;
                            end
                        end
                        default:
                        begin
                            cmd_next = cfi_pkg::CMD_READ_ARRAY;
                            wc_next  = WC_FIRST;
                        end
                    endcase
                end
                WC_DATA:
                begin
                    if (cmd_reg == cfi_pkg::CMD_BUFFER_WRITE)
                    begin
                        resp.store_en = in_range;
                        status_next   = status_reg | cfi_pkg::STAT_READY;
                        if (count_reg == 8'h00)
                        begin
                            wc_next = WC_CONFIRM;
                        end
                        else
                        begin
                            count_next = count_reg - 8'd1;
                        end
                    end
                    else
                    begin
                        cmd_next = cfi_pkg::CMD_READ_ARRAY;
                        wc_next  = WC_FIRST;
                    end
                end
                WC_CONFIRM:
                begin
                    if (cmd_reg == cfi_pkg::CMD_BUFFER_WRITE &&
                        write_data == cfi_pkg::CMD_CONFIRM &&
                        (status_reg & cfi_pkg::STAT_PROGRAM_ERR) == 8'h00)
                    begin
                        wc_next     = WC_FIRST;
                        status_next = status_reg | cfi_pkg::STAT_READY;
                    end
                    else
                    begin
                        cmd_next = cfi_pkg::CMD_READ_ARRAY;
                        wc_next  = WC_FIRST;
                    end
                end
            endcase
        end
        else
        begin
            unique case (cmd_reg) inside
                cfi_pkg::CMD_PROGRAM, cfi_pkg::CMD_PROGRAM_ALT,
                cfi_pkg::CMD_ERASE, cfi_pkg::CMD_ERASE_ALT,
                cfi_pkg::CMD_CLEAR_STATUS, cfi_pkg::CMD_LOCK,
                cfi_pkg::CMD_READ_STATUS, cfi_pkg::CMD_BUFFER_WRITE:
                begin
                    resp.rd_byte = status_reg;
                end
                cfi_pkg::CMD_READ_ID:
                begin
                    resp.rd_byte = 8'h00;
                end
                cfi_pkg::CMD_QUERY:
                begin
                    resp.rd_byte = cfi_pkg::query_byte(query_idx);
                end
                cfi_pkg::CMD_READ_ARRAY:
                begin
                    resp.array_rd = in_range;
                end
                default:
                begin
                    // An unknown mode falls back to read array before the access.
                    cmd_next      = cfi_pkg::CMD_READ_ARRAY;
                    wc_next       = WC_FIRST;
                    resp.array_rd = in_range;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    <= cfi_pkg::CMD_READ_ARRAY;
            wc_reg     <= WC_FIRST;
            status_reg <= 8'h00;
            count_reg  <= 8'h00;
        end
        else if (accept)
        begin
            cmd_reg    <= cmd_next;
            wc_reg     <= wc_next;
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfi_array_mem.sv =====
// Flash array storage with registered read data and an erase sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module cfi_array_mem #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wr_data,
    output logic [7:0]         rd_data,
    output logic               busy
);

    logic [7:0]    mem [DEPTH];
    logic          busy_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rd_data_reg;

    assign busy      = busy_reg;
    assign rd_data   = rd_data_reg;
    assign mem_we    = busy_reg || wr_en;
    assign mem_waddr = busy_reg ? clr_cnt_reg : addr;
    assign mem_wdata = busy_reg ? 8'hff : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfi_flash_command_engine.sv =====
// Top level of the flash command engine: decode stage, array read stage and output register.
// Read data is registered in the stage 1 registers and then in the output register before it is presented.
// Throughput: one bus access per cycle unless the output is stalled or the erase sweep is busy.
// Reset: command state returns to read array mode with status and countdown cleared.
// After reset an erase sweep writes 0xFF to all STORE_BYTES array bytes, one per cycle,
// and no access is accepted while the sweep runs.
`timescale 1ns / 1ps
`default_nettype none

module cfi_flash_command_engine #(
    parameter int unsigned STORE_BYTES = 65536
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cfi_req_if.sink   req,
    cfi_rsp_if.source rsp
);

    localparam int unsigned AW = $clog2(STORE_BYTES);

    logic               accept;
    logic               in_range;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_rd_data;
    logic               mem_busy;
    cfi_pkg::cmd_resp_t resp;

    logic               s1_valid_reg;
    logic               s1_array_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_advance;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;

    assign in_range = (32'(req.address) + 32'(cfi_pkg::BUS_BYTES)) <= 32'(STORE_BYTES);
    assign mem_addr = AW'(req.address);

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !mem_busy && (!s1_valid_reg || s1_advance);
    assign accept     = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    cfi_cmd_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (req.opcode),
        .in_range   (in_range),
        .query_idx  (req.address[cfi_pkg::QUERY_AW-1:0]),
        .write_data (req.write_data),
        .resp       (resp)
    );

    cfi_array_mem #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_array (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && resp.array_rd),
        .wr_en   (accept && resp.store_en),
        .addr    (mem_addr),
        .wr_data (req.write_data),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_array_reg <= resp.array_rd;
            s1_byte_reg  <= resp.rd_byte;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_data_reg <= s1_array_reg ? mem_rd_data : s1_byte_reg;
        end
    end

endmodule

`default_nettype wire
